// File: src/fcp_pkg.sv
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared types, character codes and the idle state for the framed command parser.
// ----------------------------------------------------------------------------
package fcp_pkg;

	localparam logic [7:0] CH_START = 8'h24;  // '$'
	localparam logic [7:0] CH_END   = 8'h2A;  // '*'
	localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
	localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_K     = 8'h4B;  // 'K'
	localparam logic [7:0] CH_S     = 8'h53;  // 'S'

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_START,
		PH_SIGN,
		PH_ACC
	} fcp_phase_t;

	typedef struct packed {
		logic        in_frame;
		logic [3:0]  position;
		logic [7:0]  cmd_byte;
		logic [7:0]  sub_byte;
		fcp_phase_t  phase;
		logic        negative;
		logic [15:0] acc;
		logic        digit_seen;
		logic        dropped;
	} fcp_state_t;

	typedef struct packed {
		logic [7:0]         cmd_letter;
		logic [7:0]         sub_letter;
		logic signed [15:0] value;
		logic               has_digits;
		logic               overflow;
	} fcp_result_t;

	function automatic fcp_state_t fcp_idle_state();
		fcp_state_t s;
		s.in_frame   = 1'b0;
		s.position   = 4'd0;
		s.cmd_byte   = 8'd0;
		s.sub_byte   = 8'd0;
		s.phase      = PH_WAIT;
		s.negative   = 1'b0;
		s.acc        = 16'd0;
		s.digit_seen = 1'b0;
		s.dropped    = 1'b0;
		return s;
	endfunction

endpackage

// File: src/fcp_step.sv
// ----------------------------------------------------------------------------
// fcp_step
// Per-byte update of the frame parser state and the result of a closing '*'.
// ----------------------------------------------------------------------------
module fcp_step #(
	parameter int FRAME_BYTES = 12
) (
	input  logic [7:0]          rx_byte,
	input  fcp_pkg::fcp_state_t cur,
	output fcp_pkg::fcp_state_t nxt,
	output logic                emit,
	output fcp_pkg::fcp_result_t res
);
	import fcp_pkg::*;

	localparam logic [3:0] FRAME_LIMIT = 4'(FRAME_BYTES);

	fcp_state_t  upd;
	fcp_phase_t  ph;
	logic [3:0]  start_pos;
	logic [15:0] acc_next;
	logic [15:0] acc_neg;

	// acc * 10 + (byte - '0'), all mod 2^16
	assign acc_next = (cur.acc << 3) + (cur.acc << 1) + 16'({8'd0, rx_byte} - {8'd0, CH_ZERO});
	assign acc_neg  = 16'd0 - cur.acc;

	always_comb begin
		upd       = cur;
		emit      = 1'b0;
		ph        = cur.phase;
		start_pos = 4'd2;
		if (rx_byte == CH_START) begin
			upd          = fcp_idle_state();
			upd.in_frame = 1'b1;
			upd.position = 4'd1;
		end else if (cur.in_frame) begin
			if (cur.position >= FRAME_LIMIT) begin
				upd.dropped = 1'b1;
				emit        = (rx_byte == CH_END);
			end else begin
				upd.position = cur.position + 4'd1;
				if (cur.position == 4'd1)
					upd.cmd_byte = rx_byte;
				if (cur.position == 4'd2)
					upd.sub_byte = rx_byte;
				if (rx_byte == CH_END) begin
					emit = 1'b1;
				end else if (cur.position >= 4'd2) begin
					if (upd.cmd_byte == CH_K || upd.cmd_byte == CH_S)
						start_pos = 4'd3;
					if (ph == PH_WAIT && cur.position >= start_pos)
						ph = PH_START;
					unique case (ph)
						PH_WAIT: begin
						end
						PH_START: begin
							if (rx_byte == CH_SPACE) begin
								upd.phase = PH_SIGN;
							end else if (rx_byte == CH_MINUS) begin
								upd.negative = 1'b1;
								upd.phase    = PH_ACC;
							end else begin
								upd.acc        = acc_next;
								upd.digit_seen = 1'b1;
								upd.phase      = PH_ACC;
							end
						end
						PH_SIGN: begin
							if (rx_byte == CH_MINUS) begin
								upd.negative = 1'b1;
								upd.phase    = PH_ACC;
							end else begin
								upd.acc        = acc_next;
								upd.digit_seen = 1'b1;
								upd.phase      = PH_ACC;
							end
						end
						PH_ACC: begin
							upd.acc        = acc_next;
							upd.digit_seen = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_comb begin
		res.cmd_letter = upd.cmd_byte;
		res.sub_letter = upd.sub_byte;
		res.has_digits = cur.digit_seen;
		res.overflow   = upd.dropped;
		if (!cur.digit_seen)
			res.value = 16'sd0;
		else if (cur.negative)
			res.value = $signed(acc_neg);
		else
			res.value = $signed(cur.acc);
		// a finished frame drops back to idle
		nxt = emit ? fcp_idle_state() : upd;
	end

endmodule

// File: src/framed_command_parser_core.sv
// ----------------------------------------------------------------------------
// framed_command_parser_core
// Parses '$'-framed ASCII commands: command letter, sub letter, signed value.
// ----------------------------------------------------------------------------
// a closing '*' is captured in the input register when it is accepted, and its
// result is then written to the result register
// throughput: one byte per cycle; the byte register stalls only when a frame
// result is waiting and the result register is still full
// reset: arst_n clears the parser to idle (outside any frame), no result held
module framed_command_parser_core #(
	parameter int FRAME_BYTES = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_ready,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [7:0]         cmd_letter,
	output logic [7:0]         sub_letter,
	output logic signed [15:0] value,
	output logic               has_digits,
	output logic               overflow
);
	import fcp_pkg::*;

	logic        byte_valid_s1;
	logic [7:0]  byte_s1;
	fcp_state_t  state_q;
	fcp_state_t  state_next;
	logic        emit;
	fcp_result_t res;
	fcp_result_t res_q;
	logic        res_valid_q;
	logic        advance;

	fcp_step #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_step (
		.rx_byte(byte_s1),
		.cur    (state_q),
		.nxt    (state_next),
		.emit   (emit),
		.res    (res)
	);

	// byte in s1 moves on unless it makes a result that has nowhere to go
	assign advance  = byte_valid_s1 && (!emit || !res_valid_q || res_ready);
	assign rx_ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			byte_valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready)
			byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcp_idle_state();
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_q <= res;
	end

	assign res_valid  = res_valid_q;
	assign cmd_letter = res_q.cmd_letter;
	assign sub_letter = res_q.sub_letter;
	assign value      = res_q.value;
	assign has_digits = res_q.has_digits;
	assign overflow   = res_q.overflow;

endmodule

// File: verif/framed_command_parser_core_tb.sv
// ----------------------------------------------------------------------------
// framed_command_parser_core_tb
// Streams '$'-framed command text into the parser under random sender gaps and
// receiver stalls. A local frame decoder predicts each frame's letters, value,
// digit flag and overflow flag, and every result word is checked in order.
// ----------------------------------------------------------------------------
module framed_command_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcp_pkg::*;

	localparam int FRAME_BYTES = 12;
	localparam int FRAME_TARGET = 1750;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               rx_valid = 1'b0;
	logic               rx_ready;
	logic [7:0]         rx_byte = 8'd0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	logic [7:0]         cmd_letter;
	logic [7:0]         sub_letter;
	logic signed [15:0] value;
	logic               has_digits;
	logic               overflow;

	framed_command_parser_core #(
		.FRAME_BYTES(FRAME_BYTES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.cmd_letter(cmd_letter),
		.sub_letter(sub_letter),
		.value     (value),
		.has_digits(has_digits),
		.overflow  (overflow)
	);

	// decoder state
	logic        fr_open;
	logic [3:0]  fr_pos;
	logic [7:0]  fr_cmd;
	logic [7:0]  fr_sub;
	fcp_phase_t  fr_phase;
	logic        fr_neg;
	logic [15:0] fr_acc;
	logic        fr_digits;
	logic        fr_dropped;

	logic [7:0]  pending_bytes[$];
	fcp_result_t expected_results[$];
	int          stim_total;
	int          noise_total;
	int          accepted_count;
	int          mismatch_count;
	int          burst_left;
	int          gap_left;
	logic [15:0] stall_mask;
	logic [5:0]  stall_cnt;

	function automatic void reset_frame();
		fr_pos     = 4'd0;
		fr_cmd     = 8'd0;
		fr_sub     = 8'd0;
		fr_phase   = PH_WAIT;
		fr_neg     = 1'b0;
		fr_acc     = 16'd0;
		fr_digits  = 1'b0;
		fr_dropped = 1'b0;
	endfunction

	function automatic void close_frame();
		fcp_result_t r;
		r.cmd_letter = fr_cmd;
		r.sub_letter = fr_sub;
		r.value      = 16'sd0;
		if (fr_digits)
			r.value = fr_neg ? 16'd0 - fr_acc : fr_acc;
		r.has_digits = fr_digits;
		r.overflow   = fr_dropped;
		expected_results.push_back(r);
		fr_open = 1'b0;
		reset_frame();
	endfunction

	function automatic void add_digit(logic [7:0] b);
		fr_acc    = fr_acc * 16'd10 + {8'd0, b} - {8'd0, CH_ZERO};
		fr_digits = 1'b1;
		fr_phase  = PH_ACC;
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		logic [3:0] p;
		logic [3:0] data_pos;
		if (b == CH_START) begin
			reset_frame();
			fr_open = 1'b1;
			fr_pos  = 4'd1;
			return;
		end
		if (!fr_open)
			return;
		if (fr_pos >= FRAME_BYTES) begin
			fr_dropped = 1'b1;
			if (b == CH_END)
				close_frame();
			return;
		end
		p = fr_pos;
		fr_pos = fr_pos + 4'd1;
		if (p == 4'd1)
			fr_cmd = b;
		else if (p == 4'd2)
			fr_sub = b;
		if (b == CH_END) begin
			close_frame();
			return;
		end
		if (p < 4'd2)
			return;
		data_pos = (fr_cmd == CH_K || fr_cmd == CH_S) ? 4'd3 : 4'd2;
		if (fr_phase == PH_WAIT) begin
			if (p < data_pos)
				return;
			fr_phase = PH_START;
		end
		case (fr_phase)
			PH_START: begin
				if (b == CH_SPACE)
					fr_phase = PH_SIGN;
				else if (b == CH_MINUS) begin
					fr_neg   = 1'b1;
					fr_phase = PH_ACC;
				end else
					add_digit(b);
			end
			PH_SIGN: begin
				if (b == CH_MINUS) begin
					fr_neg   = 1'b1;
					fr_phase = PH_ACC;
				end else
					add_digit(b);
			end
			default: add_digit(b);
		endcase
	endfunction

	function automatic void add_byte(logic [7:0] b);
		pending_bytes.push_back(b);
		stim_total++;
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	// any byte except the framing characters
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == CH_START || b == CH_END)
			b = CH_ZERO;
		return b;
	endfunction

	function automatic void add_frame();
		logic [7:0] c;
		int         n;
		int         kind;
		kind = $urandom_range(0, 9);
		add_byte(CH_START);
		if (kind >= 8) begin
			// broken frame: raw bytes, may restart, end early or never end
			n = $urandom_range(0, 16);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 11))
					0: add_byte(CH_START);
					1: add_byte(CH_END);
					default: add_byte(8'($urandom));
				endcase
			end
			return;
		end
		case ($urandom_range(0, 4))
			0: c = CH_K;
			1: c = CH_S;
			2, 3: c = "A" + 8'($urandom_range(0, 25));
			default: c = body_byte();
		endcase
		add_byte(c);
		if (c == CH_K || c == CH_S)
			add_byte($urandom_range(0, 3) == 0 ? body_byte() : "A" + 8'($urandom_range(0, 25)));
		if ($urandom_range(0, 2) == 0)
			add_byte(CH_SPACE);
		if ($urandom_range(0, 1) == 0)
			add_byte(CH_MINUS);
		case ($urandom_range(0, 7))
			0: n = 0;
			6: n = $urandom_range(6, 9);
			7: n = $urandom_range(8, 14);
			default: n = $urandom_range(1, 5);
		endcase
		for (int i = 0; i < n; i++)
			add_byte($urandom_range(0, 7) == 0 ? body_byte() : CH_ZERO + 8'($urandom_range(0, 9)));
		add_byte(CH_END);
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("framed_command_parser_core_tb failed");
		$finish;
	end

	// sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid   <= 1'b0;
			rx_byte    <= 8'd0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (rx_valid && rx_ready) begin
				decode_byte(rx_byte);
				accepted_count++;
			end
			if (!rx_valid || rx_ready) begin
				if (gap_left != 0 || pending_bytes.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					rx_valid <= 1'b0;
				end else begin
					rx_valid <= 1'b1;
					rx_byte  <= pending_bytes.pop_front();
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
						case ($urandom_range(0, 9))
							0, 1, 2, 3: gap_left = 0;
							8: gap_left = $urandom_range(4, 12);
							default: gap_left = $urandom_range(1, 3);
						endcase
					end else
						burst_left--;
				end
			end
		end
	end

	// receiver: res_ready follows a random 16-bit pattern, replaced whenever the 6-bit counter wraps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready  <= 1'b0;
			stall_mask = 16'hFFFF;
			stall_cnt  = 6'd0;
		end else begin
			if (stall_cnt == 6'd0) begin
				case ($urandom_range(0, 3))
					0: stall_mask = 16'hFFFF;
					1: stall_mask = 16'($urandom & $urandom) | 16'h0001;
					default: stall_mask = 16'($urandom) | 16'h0001;
				endcase
			end
			res_ready <= stall_mask[stall_cnt[3:0]];
			stall_cnt = stall_cnt + 6'd1;
		end
	end

	always @(posedge clk) begin : check_proc
		fcp_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				$error("result word with no frame pending: cmd_letter %0d", cmd_letter);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("cmd_letter", want.cmd_letter, cmd_letter);
				check_field("sub_letter", want.sub_letter, sub_letter);
				check_field("value", want.value, value);
				check_field("has_digits", want.has_digits, has_digits);
				check_field("overflow", want.overflow, overflow);
			end
		end
	end

	initial begin : main_proc
		int n;
		fr_open = 1'b0;
		reset_frame();
		stim_total     = 0;
		noise_total    = 0;
		accepted_count = 0;
		mismatch_count = 0;

		// ignored byte, empty frame, restart into an 'S' command, sign without digits
		add_text("x$*$Q$S1 -9*$A-*");
		// extreme letters, value bytes past the frame byte limit
		add_byte(CH_START);
		add_byte(8'hFF);
		add_byte(8'h00);
		add_text("-123456789*");

		while (stim_total - noise_total < FRAME_TARGET) begin
			add_frame();
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					add_byte(body_byte());
				noise_total += n;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (accepted_count != stim_total)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("framed_command_parser_core_tb passed");
		else
			$display("framed_command_parser_core_tb failed");
		$finish;
	end

endmodule

// File: filelist.f
src/fcp_pkg.sv
src/fcp_step.sv
src/framed_command_parser_core.sv
verif/framed_command_parser_core_tb.sv
